### rtl/core/act_pkg.sv
// shared types, codes and constants of the box contact tracker
package act_pkg;

   localparam int MAX_BODIES_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   // request action codes
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_CHECK  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // contact event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ENTER = 2'd1;
   localparam logic [1:0] EV_STAY  = 2'd2;
   localparam logic [1:0] EV_EXIT  = 2'd3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic [7:0]         owner;
   } box_type;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] slot;
      box_type    box;
   } cmd_type;

endpackage

### rtl/core/act_front.sv
// request intake: drops meaningless requests and queues the rest
module act_front #(
   parameter int MAX_BODIES = act_pkg::MAX_BODIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [3:0]          req_body_index,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic [15:0]         req_box_width,
   input  logic [15:0]         req_box_height,
   input  logic [7:0]          req_owner_tag,
   output logic                cmd_valid,
   output act_pkg::cmd_type    cmd,
   input  logic                cmd_pop
);

   localparam int DEPTH = act_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   act_pkg::cmd_type   q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               keep;
   logic               push;
   logic               pop;
   act_pkg::cmd_type   new_cmd;

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // action code three and slots past the table are taken and dropped
   assign keep = (req_action != act_pkg::ACT_UNUSED) &&
                 (int'(req_body_index) < MAX_BODIES);
   assign push = req_valid && req_ready && keep;
   assign pop  = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.action    = req_action;
      new_cmd.slot      = req_body_index;
      new_cmd.box.x     = req_pos_x;
      new_cmd.box.y     = req_pos_y;
      new_cmd.box.w     = req_box_width;
      new_cmd.box.h     = req_box_height;
      new_cmd.box.owner = req_owner_tag;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/core/act_back.sv
// command executor: body table, contact matrix, slot scan and result register
module act_back #(
   parameter int MAX_BODIES = act_pkg::MAX_BODIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  act_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_other_index,
   output logic [1:0]        rsp_contact_event,
   output logic              rsp_last_flag
);

   localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CNT_W = $clog2(MAX_BODIES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   act_pkg::box_type       box_mem [MAX_BODIES];
   act_pkg::box_type       rd_ff;
   act_pkg::box_type       self_ff, self_in;
   logic [IDX_W-1:0]       self_slot_ff, self_slot_in;
   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       cand_ff, cand_in;
   logic                   dv_ff, dv_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [1:0]             pend_ev_ff, pend_ev_in;
   logic                   out_valid_ff, out_valid_in;
   logic [3:0]             out_idx_ff, out_idx_in;
   logic [1:0]             out_ev_ff, out_ev_in;
   logic                   out_last_ff, out_last_in;
   logic [MAX_BODIES-1:0]  valid_ff, valid_in;
   logic [MAX_BODIES-1:0]  contact_ff [MAX_BODIES];
   logic [MAX_BODIES-1:0]  contact_in [MAX_BODIES];

   logic [IDX_W-1:0]       cmd_slot;
   logic                   out_free;
   logic                   hit;
   logic                   had;
   logic                   qual;
   logic                   stall;
   logic [1:0]             ev;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;

   // half-open boxes overlap; sums are exact at 18 bits signed
   function automatic logic touches(act_pkg::box_type a, act_pkg::box_type b);
      logic signed [17:0] ax, ay, bx, by, ax_end, ay_end, bx_end, by_end;
      ax     = {{2{a.x[15]}}, a.x};
      ay     = {{2{a.y[15]}}, a.y};
      bx     = {{2{b.x[15]}}, b.x};
      by     = {{2{b.y[15]}}, b.y};
      ax_end = ax + $signed({2'b00, a.w});
      ay_end = ay + $signed({2'b00, a.h});
      bx_end = bx + $signed({2'b00, b.w});
      by_end = by + $signed({2'b00, b.h});
      return (ax < bx_end) && (ax_end > bx) && (ay < by_end) && (ay_end > by);
   endfunction

   assign cmd_slot = IDX_W'(cmd.slot);
   assign out_free = !out_valid_ff || rsp_ready;

   assign hit   = touches(self_ff, rd_ff);
   assign had   = contact_ff[self_slot_ff][cand_ff];
   assign qual  = dv_ff && (cand_ff != self_slot_ff) && valid_ff[cand_ff] &&
                  (rd_ff.owner != self_ff.owner);
   assign stall = qual && pend_valid_ff && !out_free;

   always_comb begin
      if (hit && had) begin
         ev = act_pkg::EV_STAY;
      end else if (hit) begin
         ev = act_pkg::EV_ENTER;
      end else if (had) begin
         ev = act_pkg::EV_EXIT;
      end else begin
         ev = act_pkg::EV_NONE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      self_in       = self_ff;
      self_slot_in  = self_slot_ff;
      cand_in       = cand_ff;
      dv_in         = dv_ff;
      rd_idx_in     = rd_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_ev_in    = pend_ev_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_idx_in    = out_idx_ff;
      out_ev_in     = out_ev_ff;
      out_last_in   = out_last_ff;
      valid_in      = valid_ff;
      contact_in    = contact_ff;
      cmd_pop       = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cmd_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.action)
                  act_pkg::ACT_WRITE: begin
                     mem_wr_en = 1'b1;
                     if (!valid_ff[cmd_slot]) begin
                        for (int r = 0; r < MAX_BODIES; r++) begin
                           contact_in[r][cmd_slot] = 1'b0;
                        end
                        contact_in[cmd_slot] = '0;
                     end
                     valid_in[cmd_slot] = 1'b1;
                  end
                  act_pkg::ACT_REMOVE: begin
                     for (int r = 0; r < MAX_BODIES; r++) begin
                        contact_in[r][cmd_slot] = 1'b0;
                     end
                     contact_in[cmd_slot] = '0;
                     valid_in[cmd_slot]   = 1'b0;
                  end
                  act_pkg::ACT_CHECK: begin
                     if (valid_ff[cmd_slot]) begin
                        mem_rd_en    = 1'b1;
                        self_slot_in = cmd_slot;
                        state_in     = ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            self_in     = rd_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            cand_in     = '0;
            dv_in       = 1'b1;
            rd_idx_in   = CNT_W'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (!stall) begin
               if (qual) begin
                  contact_in[self_slot_ff][cand_ff] = hit;
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_idx_in   = 4'(pend_idx_ff);
                     out_ev_in    = pend_ev_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = cand_ff;
                  pend_ev_in    = ev;
               end
               if (rd_idx_ff < CNT_W'(MAX_BODIES)) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rd_idx_ff[IDX_W-1:0];
                  cand_in     = rd_idx_ff[IDX_W-1:0];
                  dv_in       = 1'b1;
                  rd_idx_in   = rd_idx_ff + 1'b1;
               end else begin
                  dv_in    = 1'b0;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_idx_in    = 4'(pend_idx_ff);
               out_ev_in     = pend_ev_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dv_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         for (int r = 0; r < MAX_BODIES; r++) begin
            contact_ff[r] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         dv_ff         <= dv_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         valid_ff      <= valid_in;
         contact_ff    <= contact_in;
      end
   end

   always_ff @(posedge clock) begin
      self_ff      <= self_in;
      self_slot_ff <= self_slot_in;
      cand_ff      <= cand_in;
      rd_idx_ff    <= rd_idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_ev_ff   <= pend_ev_in;
      out_idx_ff   <= out_idx_in;
      out_ev_ff    <= out_ev_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         box_mem[cmd_slot] <= cmd.box;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_ff <= box_mem[mem_rd_addr];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_other_index   = out_idx_ff;
   assign rsp_contact_event = out_ev_ff;
   assign rsp_last_flag     = out_last_ff;

endmodule

### rtl/core/aabb_contact_tracker.sv
// top level of the axis-aligned box contact tracker
//
// req_ channel: one transaction per command. action 0 writes a body box
// (corner, width, height, owner), action 1 removes a body, action 2 checks
// one body against every other valid body of a different owner. action 3
// and slots at or past MAX_BODIES are taken and dropped.
// rsp_ channel: one transaction per compared pair of a check, in rising
// slot order, carrying the other slot, the event (none, enter, stay, exit)
// and a last flag on the final one. writes and removes give no transaction.
// a two-entry command queue parts intake from execution, so req_ready stays
// high while the executor works, until the queue fills.
// steps: a write or remove takes effect as the executor pops it from the
// queue. a check of a valid body reads the checked body in a load state,
// then makes one table read per slot through the single read port of the
// body table, then passes on the final result in a flush state. the executor
// takes no further command from the queue until the check has finished.
// reset: clears all slot valid bits, the contact matrix, the queue and the
// result register; box contents stay unknown until written.
// a stalled receiver holds the result register; the scan then pauses at the
// second result it cannot pass on, and the queue fills behind it.
module aabb_contact_tracker #(
   parameter int MAX_BODIES = act_pkg::MAX_BODIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_body_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_box_width,
   input  logic [15:0]        req_box_height,
   input  logic [7:0]         req_owner_tag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_other_index,
   output logic [1:0]         rsp_contact_event,
   output logic               rsp_last_flag
);

   // queue head toward the executor
   logic             cmd_valid;
   act_pkg::cmd_type cmd;
   logic             cmd_pop;

   // intake: filters dropped commands and buffers the rest
   act_front #(
      .MAX_BODIES (MAX_BODIES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_body_index (req_body_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .req_owner_tag  (req_owner_tag),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // executor: body table, contact matrix and the per-slot scan
   act_back #(
      .MAX_BODIES (MAX_BODIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_other_index   (rsp_other_index),
      .rsp_contact_event (rsp_contact_event),
      .rsp_last_flag     (rsp_last_flag)
   );

endmodule

### rtl/core/act_checker.sv
// port-level checks of the contact tracker and their bind
module act_checker #(
   parameter int MAX_BODIES = act_pkg::MAX_BODIES_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_other_index,
   input logic [1:0] rsp_contact_event,
   input logic       rsp_last_flag
);

   logic       seen_check_ff;
   logic       mid_ff;
   logic [3:0] prev_idx_ff;
   logic       small_table;

   assign small_table = (MAX_BODIES < 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_check_ff <= 1'b0;
         mid_ff        <= 1'b0;
      end else begin
         if (req_valid && req_ready && (req_action == act_pkg::ACT_CHECK)) begin
            seen_check_ff <= 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            mid_ff <= !rsp_last_flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_idx_ff <= rsp_other_index;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_other_index) &&
      $stable(rsp_contact_event) && $stable(rsp_last_flag))
      else $error("result changed while stalled");

   // results of one check come in rising slot order
   a_rising: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mid_ff && (MAX_BODIES <= 16) |-> rsp_other_index > prev_idx_ff)
      else $error("result slots not rising within a check");

   // other slot lies inside the table
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && small_table |-> int'(rsp_other_index) < MAX_BODIES)
      else $error("result slot beyond table");

   // no result before any check was taken
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_check_ff)
      else $error("result without a check");

endmodule

bind aabb_contact_tracker act_checker #(
   .MAX_BODIES (MAX_BODIES)
) u_act_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_other_index   (rsp_other_index),
   .rsp_contact_event (rsp_contact_event),
   .rsp_last_flag     (rsp_last_flag)
);
